FILE: rtl/bceb_pkg.sv
// Package for the cross-erosion boundary core: field widths, register indexes,
// size defaults and the result item type.
// No dependencies; the interfaces and the core import it.
package bceb_pkg;

   // Field widths fixed by the item formats.
   localparam int PIX_W     = 8;
   localparam int POS_W     = 12;
   localparam int CFG_W     = 13;
   localparam int CSR_IDX_W = 2;

   // Default size limits of the line stores.
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   // Frame size after reset, before saturation to the limits.
   localparam int RST_WIDTH  = 640;
   localparam int RST_HEIGHT = 480;

   // Grey value of white background.
   localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1
   } csr_idx_type;

   // One result item.
   typedef struct packed {
      logic [POS_W-1:0] out_row;
      logic [POS_W-1:0] out_col;
      logic             eroded_black;
      logic             boundary_black;
      logic             last_of_run;
   } result_type;

endpackage

FILE: rtl/bceb_req_if.sv
// Input channel of the cross-erosion boundary core: one raw pixel per item.
// Depends on bceb_pkg for the pixel width.
interface bceb_req_if;
   import bceb_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

FILE: rtl/bceb_rsp_if.sv
// Result channel of the cross-erosion boundary core: position and flags per item.
// Depends on bceb_pkg for the position width.
interface bceb_rsp_if;
   import bceb_pkg::*;

   logic             valid;
   logic             ready;
   logic [POS_W-1:0] out_row;
   logic [POS_W-1:0] out_col;
   logic             eroded_black;
   logic             boundary_black;
   logic             last_of_run;

   modport source (output valid, output out_row, output out_col, output eroded_black,
                   output boundary_black, output last_of_run, input ready);
   modport sink   (input valid, input out_row, input out_col, input eroded_black,
                   input boundary_black, input last_of_run, output ready);
endinterface

FILE: rtl/binary_cross_erosion_boundary_core.sv
// Streaming 3x3 cross erosion with boundary extraction over a raster pixel stream.
// A result passes the stage register s1_ff and then the output register pair before it is offered.
// Throughput: one pixel per cycle while the result port keeps up; in the last row of a frame each
// pixel gives two items, so there the single result port holds back the pixel input.
// Reset (synchronous): counters cleared, frame size back to 640 x 480 saturated to the
// limits; the line stores are not cleared and need no clearing pass.
module binary_cross_erosion_boundary_core #(
   parameter int MAX_WIDTH  = bceb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bceb_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   bceb_req_if.sink                       req_chan,
   bceb_rsp_if.source                     rsp_chan,
   input  logic                           csr_we,
   input  logic [bceb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bceb_pkg::CFG_W-1:0]     csr_data
);
   import bceb_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   localparam logic [AW-1:0] WLAST_RST =
      AW'(((RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH) - 1);
   localparam logic [RW-1:0] HLAST_RST =
      RW'(((RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT) - 1);

   // Work carried from acceptance to the stage that sees the right neighbour.
   typedef struct packed {
      logic [RW-1:0]    row;
      logic [AW-1:0]    col;
      logic [PIX_W-1:0] centre;
      logic             pre_black;
      logic             has_upper;
      logic             last_row;
      logic             pix_not_white;
   } stage_type;

   // Configuration: last column and last row indexes, saturated at write time.
   logic [AW-1:0] wlast_ff, wlast_in;
   logic [RW-1:0] hlast_ff, hlast_in;

   always_comb begin
      if (csr_data == '0) begin
         wlast_in = '0;
      end else if (32'(csr_data) > 32'(MAX_WIDTH)) begin
         wlast_in = AW'(MAX_WIDTH - 1);
      end else begin
         wlast_in = AW'(csr_data - 1'b1);
      end
      if (csr_data == '0) begin
         hlast_in = '0;
      end else if (32'(csr_data) > 32'(MAX_HEIGHT)) begin
         hlast_in = RW'(MAX_HEIGHT - 1);
      end else begin
         hlast_in = RW'(csr_data - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff <= WLAST_RST;
         hlast_ff <= HLAST_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  wlast_ff <= wlast_in;
            REG_FRAME_HEIGHT: hlast_ff <= hlast_in;
            default: ;
         endcase
      end
   end

   // Handshake control signals.
   logic s1_valid_ff, s1_valid_in;
   logic out_free;
   logic accept;

   assign req_chan.ready = !s1_valid_ff || out_free;
   assign accept         = req_chan.valid && req_chan.ready;

   // Raster position of the item at the input.
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] col_ff, col_in;
   logic          row_end;
   logic          last_row;
   logic          has_upper;

   assign row_end   = col_ff >= wlast_ff;
   assign last_row  = row_ff >= hlast_ff;
   assign has_upper = row_ff != '0;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (row_end) begin
         col_in = '0;
         row_in = last_row ? '0 : RW'(row_ff + 1'b1);
      end else begin
         col_in = AW'(col_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Line stores. Each item writes its own column (the flag store only when the item has an upper
   // row) and prefetches the next one, which serves as its right neighbour and as the centre of the next item.
   logic [PIX_W-1:0] store_mem [MAX_WIDTH];
   logic             flag_mem  [MAX_WIDTH];
   logic [AW-1:0]    rd_addr;
   logic [PIX_W-1:0] store_q_ff;
   logic             flag_q_ff;
   logic             fwd_store_ff;
   logic             fwd_flag_ff;
   logic [PIX_W-1:0] fwd_pix_ff;
   logic             fwd_zero_ff;
   logic [PIX_W-1:0] centre;
   logic             upper_zero;

   assign rd_addr = row_end ? '0 : AW'(col_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (accept) begin
         store_mem[col_ff] <= req_chan.pixel;
         store_q_ff        <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (has_upper) begin
            flag_mem[col_ff] <= (centre == '0);
         end
         flag_q_ff <= flag_mem[rd_addr];
      end
   end

   // Forwarding for a one-column frame, where the read hits the entry being written.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_store_ff <= 1'b0;
         fwd_flag_ff  <= 1'b0;
      end else if (accept) begin
         fwd_store_ff <= (rd_addr == col_ff);
         fwd_flag_ff  <= (rd_addr == col_ff) && has_upper;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_pix_ff  <= req_chan.pixel;
         fwd_zero_ff <= (centre == '0);
      end
   end

   assign centre     = fwd_store_ff ? fwd_pix_ff : store_q_ff;
   assign upper_zero = fwd_flag_ff ? fwd_zero_ff : flag_q_ff;

   // Left neighbour: the centre of the previous item in the row.
   logic [PIX_W-1:0] left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (accept && has_upper) begin
         left_ff <= centre;
      end
   end

   // Everything of the erosion test except the right neighbour is known here.
   logic      border;
   stage_type s1_in;
   stage_type s1_ff;

   assign border = (row_ff == RW'(1)) || (row_ff > hlast_ff) || (col_ff == '0) || row_end;

   always_comb begin
      s1_in.row           = row_ff;
      s1_in.col           = col_ff;
      s1_in.centre        = centre;
      s1_in.pre_black     = !border && (centre == '0) && upper_zero &&
                            (req_chan.pixel == '0) && (left_ff == '0);
      s1_in.has_upper     = has_upper;
      s1_in.last_row      = last_row;
      s1_in.pix_not_white = req_chan.pixel != PIX_WHITE;
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // The prefetched entry now holds the right neighbour; finish both results.
   logic       er_black;
   result_type res_a;
   result_type res_b;

   assign er_black = s1_ff.pre_black && (centre == '0);

   always_comb begin
      res_a.out_row        = POS_W'(RW'(s1_ff.row - 1'b1));
      res_a.out_col        = POS_W'(s1_ff.col);
      res_a.eroded_black   = er_black;
      res_a.boundary_black = er_black ? (s1_ff.centre != '0) : (s1_ff.centre != PIX_WHITE);
      res_a.last_of_run    = !s1_ff.last_row;
      res_b.out_row        = POS_W'(s1_ff.row);
      res_b.out_col        = POS_W'(s1_ff.col);
      res_b.eroded_black   = 1'b0;
      res_b.boundary_black = s1_ff.pix_not_white;
      res_b.last_of_run    = 1'b1;
   end

   // Output register pair: the upper-row result goes first, the last-row one after it.
   result_type outa_ff;
   result_type outb_ff;
   result_type out_sel;
   logic       a_pend_ff, a_pend_in;
   logic       b_pend_ff, b_pend_in;
   logic       take;

   assign take     = rsp_chan.valid && rsp_chan.ready;
   assign out_free = !(a_pend_ff || b_pend_ff) || (rsp_chan.ready && (a_pend_ff ^ b_pend_ff));

   always_comb begin
      a_pend_in = a_pend_ff;
      b_pend_in = b_pend_ff;
      if (s1_valid_ff && out_free) begin
         a_pend_in = s1_ff.has_upper;
         b_pend_in = s1_ff.last_row;
      end else if (take) begin
         if (a_pend_ff) begin
            a_pend_in = 1'b0;
         end else begin
            b_pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_pend_ff <= 1'b0;
         b_pend_ff <= 1'b0;
      end else begin
         a_pend_ff <= a_pend_in;
         b_pend_ff <= b_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && out_free) begin
         outa_ff <= res_a;
         outb_ff <= res_b;
      end
   end

   assign out_sel                 = a_pend_ff ? outa_ff : outb_ff;
   assign rsp_chan.valid          = a_pend_ff || b_pend_ff;
   assign rsp_chan.out_row        = out_sel.out_row;
   assign rsp_chan.out_col        = out_sel.out_col;
   assign rsp_chan.eroded_black   = out_sel.eroded_black;
   assign rsp_chan.boundary_black = out_sel.boundary_black;
   assign rsp_chan.last_of_run    = out_sel.last_of_run;

endmodule
